>>> sv/nlh_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table for the nearest landmark finder.
// No dependencies.
package nlh_pkg;

   localparam int NUM_PLACES   = 5;
   localparam int ANG_W        = 34;   // CORDIC / Q30 working word
   localparam int CORDIC_STEPS = 30;
   localparam int STEP_W       = 5;

   localparam logic [31:0] CONV_UDEG = 32'd314410567;   // pi/180e6 * 2^54
   localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic [31:0] RADIUS_M  = 32'd6371000;
   localparam logic [24:0] DIST_MAX  = 25'd20037508;
   localparam logic [30:0] Q30_ONE   = 31'h4000_0000;

   localparam logic signed [30:0] DEG90  = 31'sd90000000;
   localparam logic signed [30:0] DEG180 = 31'sd180000000;
   localparam logic signed [30:0] DEG360 = 31'sd360000000;

   localparam logic [25:0] LON_BASE   = 26'd30000000;
   localparam logic [25:0] LAT_BASE   = 26'd31000000;
   localparam logic [25:0] PLACE_STEP = 26'd100000;

   localparam logic [24:0] NEAR_RESET = 25'd5000;
   localparam logic [24:0] MID_RESET  = 25'd20000;

   typedef enum logic {
      REG_NEAR_LIMIT = 1'b0,
      REG_MID_LIMIT  = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      BAND_NEAR = 2'd0,
      BAND_MID  = 2'd1,
      BAND_FAR  = 2'd2
   } band_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_COS1_MUL,
      ST_COS1_ROT,
      ST_SLAT_MUL,
      ST_SLAT_ROT,
      ST_SLON_MUL,
      ST_SLON_ROT,
      ST_COS2_MUL,
      ST_COS2_ROT,
      ST_CC_MUL,
      ST_T1_MUL,
      ST_T2_MUL,
      ST_T3_MUL,
      ST_SUM,
      ST_SQRT_A,
      ST_SQRT_B,
      ST_ATAN,
      ST_DIST_MUL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic vector;   // 1: vectoring (atan2), 0: rotation (sin/cos)
   } cordic_ctl_type;

   // truncated Q30 atan(2^-i)
   function automatic logic [31:0] atan_at(input logic [STEP_W-1:0] i);
      logic [31:0] v;
      unique case (i)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;
         5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000008;
         5'd28: v = 32'h00000004;
         5'd29: v = 32'h00000002;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

>>> sv/nlh_cordic.sv
`timescale 1ns / 1ps
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// Depends on nlh_pkg.
module nlh_cordic (
   input  logic                               clock,
   input  logic                               reset,
   input  nlh_pkg::cordic_ctl_type            ctl,
   input  logic signed [nlh_pkg::ANG_W-1:0]   x_load,
   input  logic signed [nlh_pkg::ANG_W-1:0]   y_load,
   input  logic signed [nlh_pkg::ANG_W-1:0]   z_load,
   output logic signed [nlh_pkg::ANG_W-1:0]   x_out,
   output logic signed [nlh_pkg::ANG_W-1:0]   y_out,
   output logic signed [nlh_pkg::ANG_W-1:0]   z_out,
   output logic                               busy
);

   logic signed [nlh_pkg::ANG_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [nlh_pkg::ANG_W-1:0] dx, dy, at;
   logic [nlh_pkg::STEP_W-1:0]       step_ff, step_in;
   logic                             vec_ff, vec_in;
   logic                             busy_ff, busy_in;
   logic                             dir;

   always_comb begin
      dx  = y_ff >>> step_ff;
      dy  = x_ff >>> step_ff;
      at  = $signed({2'b00, nlh_pkg::atan_at(step_ff)});
      // dir high: x -= dx, y += dy, z -= atan
      dir = vec_ff ? y_ff[nlh_pkg::ANG_W-1] : ~z_ff[nlh_pkg::ANG_W-1];
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      vec_in  = vec_ff;
      busy_in = busy_ff;
      if (ctl.load) begin
         x_in    = x_load;
         y_in    = y_load;
         z_in    = z_load;
         vec_in  = ctl.vector;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (dir) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
         if (step_ff == nlh_pkg::STEP_W'(nlh_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
      vec_ff  <= vec_in;
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
   assign busy  = busy_ff;

endmodule

>>> sv/nlh_isqrt.sv
`timescale 1ns / 1ps
// Bitwise integer square root, one result bit per cycle.
// Depends on nothing but the clock and reset.
module nlh_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  logic [60:0] radicand,
   output logic [30:0] root,
   output logic        busy
);

   logic [60:0] rem_ff, rem_in;
   logic [60:0] res_ff, res_in;
   logic [4:0]  k_ff, k_in;
   logic        busy_ff, busy_in;
   logic [61:0] bitv, trial;

   always_comb begin
      bitv    = 62'd1 << {k_ff, 1'b0};
      trial   = {1'b0, res_ff} + bitv;
      rem_in  = rem_ff;
      res_in  = res_ff;
      k_in    = k_ff;
      busy_in = busy_ff;
      if (load) begin
         rem_in  = radicand;
         res_in  = '0;
         k_in    = 5'd30;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in = 61'({1'b0, rem_ff} - trial);
            res_in = (res_ff >> 1) + bitv[60:0];
         end else begin
            res_in = res_ff >> 1;
         end
         if (k_ff == 5'd0) begin
            busy_in = 1'b0;
         end else begin
            k_in = k_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      k_ff   <= k_in;
   end

   assign root = res_ff[30:0];
   assign busy = busy_ff;

endmodule

>>> sv/nearest_landmark_haversine.sv
`timescale 1ns / 1ps
// Nearest landmark by haversine distance: sequencer, shared multiplier, result register.
// Depends on nlh_pkg, nlh_cordic and nlh_isqrt.
//
// Usage:
//   Request channel (req_valid / req_stall): one GPS fix in signed microdegrees.
//   Response channel (rsp_valid / rsp_stall): nearest landmark index, band and
//   distance in metres, one response per request.
//   csr_wr_en / csr_index / csr_wr_data write the near and mid limits; write
//   only while no request is in flight.
//   Per landmark: three 30-step CORDIC rotations, two 31-step square roots and
//   one 30-step CORDIC vectoring, all run one after another on a single CORDIC
//   unit and a single root unit; products go through one 32x32 multiplier,
//   which registers each product before it is rounded.
//   One request at a time: req_stall is high from acceptance until the result
//   is moved to the response register. That register holds the result while
//   rsp_stall is high; the next request can be taken meanwhile, and its result
//   waits in the sequencer until the register frees.
//   Synchronous reset clears the sequencer and the response valid and sets the
//   limits to 5000 m and 20000 m.
module nearest_landmark_haversine #(
   parameter int NUM_PLACES = nlh_pkg::NUM_PLACES,
   parameter int IDX_W      = (NUM_PLACES > 1) ? $clog2(NUM_PLACES) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [28:0]        req_lon_udeg,
   input  logic signed [27:0]        req_lat_udeg,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [IDX_W-1:0]          rsp_place_index,
   output logic [1:0]                rsp_proximity_band,
   output logic [24:0]               rsp_distance_m,
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [24:0]               csr_wr_data
);

   localparam int W = nlh_pkg::ANG_W;

   function automatic logic signed [30:0] wrap_udeg(input logic signed [30:0] u);
      logic signed [30:0] w;
      w = u;
      if (u > nlh_pkg::DEG180) begin
         w = u - nlh_pkg::DEG360;
      end else if (u < -nlh_pkg::DEG180) begin
         w = u + nlh_pkg::DEG360;
      end
      return w;
   endfunction

   nlh_pkg::state_type state_ff, state_in;
   logic               ph_ff, ph_in;

   logic signed [28:0] lon_ff, lon_in;
   logic signed [27:0] lat_ff, lat_in;
   logic [25:0]        lat2_ff, lat2_in, lon2_ff, lon2_in;
   logic [IDX_W-1:0]   idx_ff, idx_in, best_idx_ff, best_idx_in;
   logic signed [W:0]  best_ff, best_in;
   logic               flip_ff, flip_in;
   logic signed [W-1:0] cos1_ff, cos1_in, s1_ff, s1_in, s2_ff, s2_in, cl_ff, cl_in;
   logic signed [W-1:0] cc_ff, cc_in, t1_ff, t1_in, t2_ff, t2_in, t3_ff, t3_in;
   logic [30:0]        a_ff, a_in, ra_ff, ra_in;
   logic [24:0]        dist_ff, dist_in;
   logic [24:0]        near_ff, near_in, mid_ff, mid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic [1:0]         rsp_band_ff, rsp_band_in;
   logic [24:0]        rsp_dist_ff, rsp_dist_in;

   // shared multiplier
   logic signed [W:0]  opa, opb, maga, magb;
   logic [63:0]        prod_ff, prod_in;
   logic               neg_ff, neg_in;
   logic [4:0]         sh;
   logic [64:0]        rnd_sum, rnd_shift;
   logic [33:0]        r_mag;
   logic signed [W:0]  mres;

   // operand helpers
   logic signed [30:0] lat31, lon31, lat2s, lon2s, cu, cm, cmr;
   logic               cflip;
   logic signed [W:0]  asum, cval;
   logic [30:0]        a_clamp;
   logic               last_place, out_free;

   nlh_pkg::cordic_ctl_type cor_ctl;
   logic signed [W-1:0]     cor_xl, cor_yl, cor_zl, cor_x, cor_y, cor_z;
   logic                    cor_busy;
   logic                    sq_load, sq_busy;
   logic [60:0]             sq_rad;
   logic [30:0]             sq_root;

   nlh_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .ctl    (cor_ctl),
      .x_load (cor_xl),
      .y_load (cor_yl),
      .z_load (cor_zl),
      .x_out  (cor_x),
      .y_out  (cor_y),
      .z_out  (cor_z),
      .busy   (cor_busy)
   );

   nlh_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .load     (sq_load),
      .radicand (sq_rad),
      .root     (sq_root),
      .busy     (sq_busy)
   );

   // operands and rounding
   always_comb begin
      lat31 = 31'(lat_ff);
      lon31 = 31'(lon_ff);
      lat2s = $signed({5'b0, lat2_ff});
      lon2s = $signed({5'b0, lon2_ff});
      cu    = wrap_udeg(lat31);
      cm    = cu[30] ? -cu : cu;
      cflip = cm > nlh_pkg::DEG90;
      cmr   = cflip ? nlh_pkg::DEG180 - cm : cm;

      opa = '0;
      opb = $signed({3'b000, nlh_pkg::CONV_UDEG});
      sh  = 5'd30;
      unique case (state_ff)
         nlh_pkg::ST_COS1_MUL: begin
            opa = (W+1)'(cmr);
            sh  = 5'd24;
         end
         nlh_pkg::ST_SLAT_MUL: begin
            opa = (W+1)'(wrap_udeg(lat2s - lat31));
            sh  = 5'd25;
         end
         nlh_pkg::ST_SLON_MUL: begin
            opa = (W+1)'(wrap_udeg(lon2s - lon31));
            sh  = 5'd25;
         end
         nlh_pkg::ST_COS2_MUL: begin
            opa = (W+1)'(lat2s);
            sh  = 5'd24;
         end
         nlh_pkg::ST_CC_MUL: begin
            opa = (W+1)'(cos1_ff);
            opb = (W+1)'(cl_ff);
         end
         nlh_pkg::ST_T1_MUL: begin
            opa = (W+1)'(s1_ff);
            opb = (W+1)'(s1_ff);
         end
         nlh_pkg::ST_T2_MUL: begin
            opa = (W+1)'(s2_ff);
            opb = (W+1)'(s2_ff);
         end
         nlh_pkg::ST_T3_MUL: begin
            opa = (W+1)'(cc_ff);
            opb = (W+1)'(t2_ff);
         end
         nlh_pkg::ST_DIST_MUL: begin
            opa = best_ff[W] ? '0 : best_ff;
            opb = $signed({3'b000, nlh_pkg::RADIUS_M});
         end
         default: begin
            opa = '0;
         end
      endcase

      maga    = opa[W] ? -opa : opa;
      magb    = opb[W] ? -opb : opb;
      prod_in = maga[31:0] * magb[31:0];
      neg_in  = opa[W] ^ opb[W];

      rnd_sum   = {1'b0, prod_ff} + (65'd1 << (sh - 5'd1));
      rnd_shift = rnd_sum >> sh;
      r_mag     = rnd_shift[33:0];
      mres      = neg_ff ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});

      asum    = (W+1)'(t1_ff) + (W+1)'(t3_ff);
      if (asum[W]) begin
         a_clamp = '0;
      end else if (asum > $signed({4'b0000, nlh_pkg::Q30_ONE})) begin
         a_clamp = nlh_pkg::Q30_ONE;
      end else begin
         a_clamp = asum[30:0];
      end
      cval       = $signed({cor_z, 1'b0});
      last_place = idx_ff == IDX_W'(NUM_PLACES - 1);
      out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nlh_pkg::ST_IDLE:     if (req_valid) state_in = nlh_pkg::ST_COS1_MUL;
         nlh_pkg::ST_COS1_MUL: if (ph_ff) state_in = nlh_pkg::ST_COS1_ROT;
         nlh_pkg::ST_COS1_ROT: if (!cor_busy) state_in = nlh_pkg::ST_SLAT_MUL;
         nlh_pkg::ST_SLAT_MUL: if (ph_ff) state_in = nlh_pkg::ST_SLAT_ROT;
         nlh_pkg::ST_SLAT_ROT: if (!cor_busy) state_in = nlh_pkg::ST_SLON_MUL;
         nlh_pkg::ST_SLON_MUL: if (ph_ff) state_in = nlh_pkg::ST_SLON_ROT;
         nlh_pkg::ST_SLON_ROT: if (!cor_busy) state_in = nlh_pkg::ST_COS2_MUL;
         nlh_pkg::ST_COS2_MUL: if (ph_ff) state_in = nlh_pkg::ST_COS2_ROT;
         nlh_pkg::ST_COS2_ROT: if (!cor_busy) state_in = nlh_pkg::ST_CC_MUL;
         nlh_pkg::ST_CC_MUL:   if (ph_ff) state_in = nlh_pkg::ST_T1_MUL;
         nlh_pkg::ST_T1_MUL:   if (ph_ff) state_in = nlh_pkg::ST_T2_MUL;
         nlh_pkg::ST_T2_MUL:   if (ph_ff) state_in = nlh_pkg::ST_T3_MUL;
         nlh_pkg::ST_T3_MUL:   if (ph_ff) state_in = nlh_pkg::ST_SUM;
         nlh_pkg::ST_SUM:      state_in = nlh_pkg::ST_SQRT_A;
         nlh_pkg::ST_SQRT_A:   if (!sq_busy) state_in = nlh_pkg::ST_SQRT_B;
         nlh_pkg::ST_SQRT_B:   if (!sq_busy) state_in = nlh_pkg::ST_ATAN;
         nlh_pkg::ST_ATAN: begin
            if (!cor_busy) begin
               state_in = last_place ? nlh_pkg::ST_DIST_MUL : nlh_pkg::ST_SLAT_MUL;
            end
         end
         nlh_pkg::ST_DIST_MUL: if (ph_ff) state_in = nlh_pkg::ST_OUT;
         nlh_pkg::ST_OUT:      if (out_free) state_in = nlh_pkg::ST_IDLE;
         default:              state_in = nlh_pkg::ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      ph_in       = 1'b0;
      lon_in      = lon_ff;
      lat_in      = lat_ff;
      lat2_in     = lat2_ff;
      lon2_in     = lon2_ff;
      idx_in      = idx_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      flip_in     = flip_ff;
      cos1_in     = cos1_ff;
      s1_in       = s1_ff;
      s2_in       = s2_ff;
      cl_in       = cl_ff;
      cc_in       = cc_ff;
      t1_in       = t1_ff;
      t2_in       = t2_ff;
      t3_in       = t3_ff;
      a_in        = a_ff;
      ra_in       = ra_ff;
      dist_in     = dist_ff;
      rsp_idx_in  = rsp_idx_ff;
      rsp_band_in = rsp_band_ff;
      rsp_dist_in = rsp_dist_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cor_ctl     = '0;
      cor_xl      = nlh_pkg::CORDIC_GAIN;
      cor_yl      = '0;
      cor_zl      = $signed(mres[W-1:0]);
      sq_load     = 1'b0;
      sq_rad      = {a_clamp, 30'b0};

      near_in = near_ff;
      mid_in  = mid_ff;
      if (csr_wr_en) begin
         if (csr_index == nlh_pkg::REG_NEAR_LIMIT) begin
            near_in = csr_wr_data;
         end else begin
            mid_in = csr_wr_data;
         end
      end

      unique case (state_ff)
         nlh_pkg::ST_IDLE: begin
            if (req_valid) begin
               lon_in  = req_lon_udeg;
               lat_in  = req_lat_udeg;
               idx_in  = '0;
               lat2_in = nlh_pkg::LAT_BASE;
               lon2_in = nlh_pkg::LON_BASE;
            end
         end
         nlh_pkg::ST_COS1_MUL, nlh_pkg::ST_SLAT_MUL, nlh_pkg::ST_SLON_MUL,
         nlh_pkg::ST_COS2_MUL: begin
            ph_in = !ph_ff;
            if (state_ff == nlh_pkg::ST_COS1_MUL && !ph_ff) begin
               flip_in = cflip;
            end
            cor_ctl.load = ph_ff;
         end
         nlh_pkg::ST_COS1_ROT: if (!cor_busy) cos1_in = flip_ff ? -cor_x : cor_x;
         nlh_pkg::ST_SLAT_ROT: if (!cor_busy) s1_in = cor_y;
         nlh_pkg::ST_SLON_ROT: if (!cor_busy) s2_in = cor_y;
         nlh_pkg::ST_COS2_ROT: if (!cor_busy) cl_in = cor_x;
         nlh_pkg::ST_CC_MUL: begin
            ph_in = !ph_ff;
            if (ph_ff) cc_in = $signed(mres[W-1:0]);
         end
         nlh_pkg::ST_T1_MUL: begin
            ph_in = !ph_ff;
            if (ph_ff) t1_in = $signed(mres[W-1:0]);
         end
         nlh_pkg::ST_T2_MUL: begin
            ph_in = !ph_ff;
            if (ph_ff) t2_in = $signed(mres[W-1:0]);
         end
         nlh_pkg::ST_T3_MUL: begin
            ph_in = !ph_ff;
            if (ph_ff) t3_in = $signed(mres[W-1:0]);
         end
         nlh_pkg::ST_SUM: begin
            a_in    = a_clamp;
            sq_load = 1'b1;
         end
         nlh_pkg::ST_SQRT_A: begin
            if (!sq_busy) begin
               ra_in   = sq_root;
               sq_rad  = {nlh_pkg::Q30_ONE - a_ff, 30'b0};
               sq_load = 1'b1;
            end
         end
         nlh_pkg::ST_SQRT_B: begin
            if (!sq_busy) begin
               cor_ctl.load   = 1'b1;
               cor_ctl.vector = 1'b1;
               cor_xl = $signed({3'b000, sq_root});
               cor_yl = $signed({3'b000, ra_ff});
               cor_zl = '0;
            end
         end
         nlh_pkg::ST_ATAN: begin
            if (!cor_busy) begin
               if (idx_ff == '0 || cval < best_ff) begin
                  best_in     = cval;
                  best_idx_in = idx_ff;
               end
               if (!last_place) begin
                  idx_in  = idx_ff + 1'b1;
                  lat2_in = lat2_ff + nlh_pkg::PLACE_STEP;
                  lon2_in = lon2_ff + nlh_pkg::PLACE_STEP;
               end
            end
         end
         nlh_pkg::ST_DIST_MUL: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               dist_in = (r_mag > 34'(nlh_pkg::DIST_MAX)) ? nlh_pkg::DIST_MAX : r_mag[24:0];
            end
         end
         nlh_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = best_idx_ff;
               rsp_dist_in  = dist_ff;
               if (dist_ff < near_ff) begin
                  rsp_band_in = nlh_pkg::BAND_NEAR;
               end else if (dist_ff < mid_ff) begin
                  rsp_band_in = nlh_pkg::BAND_MID;
               end else begin
                  rsp_band_in = nlh_pkg::BAND_FAR;
               end
            end
         end
         default: begin
            ph_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nlh_pkg::ST_IDLE;
         ph_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         near_ff      <= nlh_pkg::NEAR_RESET;
         mid_ff       <= nlh_pkg::MID_RESET;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         rsp_valid_ff <= rsp_valid_in;
         near_ff      <= near_in;
         mid_ff       <= mid_in;
      end
   end

   always_ff @(posedge clock) begin
      lon_ff      <= lon_in;
      lat_ff      <= lat_in;
      lat2_ff     <= lat2_in;
      lon2_ff     <= lon2_in;
      idx_ff      <= idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      flip_ff     <= flip_in;
      cos1_ff     <= cos1_in;
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      cl_ff       <= cl_in;
      cc_ff       <= cc_in;
      t1_ff       <= t1_in;
      t2_ff       <= t2_in;
      t3_ff       <= t3_in;
      a_ff        <= a_in;
      ra_ff       <= ra_in;
      dist_ff     <= dist_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_band_ff <= rsp_band_in;
      rsp_dist_ff <= rsp_dist_in;
   end

   assign req_stall          = state_ff != nlh_pkg::ST_IDLE;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_place_index    = rsp_idx_ff;
   assign rsp_proximity_band = rsp_band_ff;
   assign rsp_distance_m     = rsp_dist_ff;

   // the two iterative units are never busy together
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cor_busy && sq_busy))
      else $error("cordic and root unit busy together");

   // a taken request closes the input until its result is handed on
   a_stall_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request port open while busy");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_place_index <= IDX_W'(NUM_PLACES - 1)
                     && rsp_distance_m <= nlh_pkg::DIST_MAX
                     && rsp_proximity_band != 2'd3))
      else $error("response out of range");

endmodule
